// ===== sv/hrf_pkg.sv =====
// Shared types, constants and helpers for the HTTP request framer.
`default_nettype none
package hrf_pkg;

    localparam int LengthBits = 24;
    localparam int CountBits  = 25;

    localparam logic [3:0] KeyLen = 4'd15;

    localparam logic [LengthBits-1:0] LengthMax = {LengthBits{1'b1}};
    localparam logic [CountBits-1:0]  CountMax  = {CountBits{1'b1}};

    localparam logic [7:0] ChCr    = 8'h0D;
    localparam logic [7:0] ChLf    = 8'h0A;
    localparam logic [7:0] ChSpace = 8'h20;
    localparam logic [7:0] ChTab   = 8'h09;
    localparam logic [7:0] ChVt    = 8'h0B;
    localparam logic [7:0] ChFf    = 8'h0C;
    localparam logic [7:0] ChPlus  = 8'h2B;
    localparam logic [7:0] ChMinus = 8'h2D;
    localparam logic [7:0] ChZero  = 8'h30;
    localparam logic [7:0] ChNine  = 8'h39;
    localparam logic [7:0] ChC     = 8'h43;

    typedef enum logic {
        CMD_BYTE  = 1'b0,
        CMD_CLOSE = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_ABORTED   = 2'd1,
        ST_SATURATED = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        BL_NONE    = 2'd0,
        BL_CR      = 2'd1,
        BL_CRLF    = 2'd2,
        BL_CRLFCR  = 2'd3
    } t_blank;

    typedef enum logic [1:0] {
        VP_KEY    = 2'd0,
        VP_SKIP   = 2'd1,
        VP_DIGITS = 2'd2,
        VP_DONE   = 2'd3
    } t_value_phase;

    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] data_byte;
    } t_in_beat;

    typedef struct packed {
        logic [7:0]            out_byte;
        logic                  in_body;
        logic                  hdr_complete;
        logic                  message_end;
        logic [LengthBits-1:0] body_length;
        logic [CountBits-1:0]  message_length;
        t_status               status;
    } t_out_beat;

    // Characters of the header key "Content-Length:".
    function automatic logic [7:0] key_char(input logic [3:0] pos);
        logic [7:0] ch;
        unique case (pos)
            4'd0:    ch = 8'h43;
            4'd1:    ch = 8'h6F;
            4'd2:    ch = 8'h6E;
            4'd3:    ch = 8'h74;
            4'd4:    ch = 8'h65;
            4'd5:    ch = 8'h6E;
            4'd6:    ch = 8'h74;
            4'd7:    ch = 8'h2D;
            4'd8:    ch = 8'h4C;
            4'd9:    ch = 8'h65;
            4'd10:   ch = 8'h6E;
            4'd11:   ch = 8'h67;
            4'd12:   ch = 8'h74;
            4'd13:   ch = 8'h68;
            4'd14:   ch = 8'h3A;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic is_space(input logic [7:0] ch);
        return (ch == ChSpace) || (ch == ChTab) || (ch == ChLf) ||
               (ch == ChVt) || (ch == ChFf) || (ch == ChCr);
    endfunction

endpackage
`default_nettype wire

// ===== sv/hrf_in_reg.sv =====
// Input register stage that holds one accepted beat until the engine takes it.
`default_nettype none
module hrf_in_reg
    import hrf_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_ready,
    input  wire t_in_beat i_data,
    output logic          o_valid,
    input  wire logic     i_take,
    output t_in_beat      o_data
);

    logic     r_valid;
    t_in_beat r_data;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= i_data;
        end
    end

endmodule
`default_nettype wire

// ===== sv/hrf_engine.sv =====
// Per-message framing state and the single-pass update for one beat.
`default_nettype none
module hrf_engine
    import hrf_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_step,
    input  wire t_in_beat              i_beat,
    input  wire logic [LengthBits-1:0] i_limit,
    output t_out_beat                  o_result
);

    t_blank                r_blank,     n_blank;
    logic                  r_hdr_done,  n_hdr_done;
    logic [3:0]            r_key_pos,   n_key_pos;
    t_value_phase          r_phase,     n_phase;
    logic                  r_neg,       n_neg;
    logic [LengthBits-1:0] r_parsed,    n_parsed;
    logic                  r_sat,       n_sat;
    logic [LengthBits-1:0] r_remaining, n_remaining;
    logic [CountBits-1:0]  r_count,     n_count;

    logic [7:0]            c;
    logic                  c_digit;
    logic [3:0]            digit;
    logic [LengthBits+3:0] acc;

    logic [3:0]            p_key_pos;
    t_value_phase          p_phase;
    logic                  p_neg;
    logic [LengthBits-1:0] p_parsed;
    logic                  p_sat;

    logic                  f_hdr;
    logic                  f_end;
    logic                  f_clear;
    t_blank                b_next;

    assign c       = i_beat.data_byte;
    assign c_digit = (c >= ChZero) && (c <= ChNine);
    assign digit   = c[3:0];
    assign acc     = ({4'b0, r_parsed} << 3) + ({4'b0, r_parsed} << 1)
                   + {{LengthBits{1'b0}}, digit};

    // Header key match and value parse.
    always_comb begin
        p_key_pos = r_key_pos;
        p_phase   = r_phase;
        p_neg     = r_neg;
        p_parsed  = r_parsed;
        p_sat     = r_sat;
        unique case (r_phase)
            VP_KEY: begin
                if ((r_key_pos < KeyLen) && (c == key_char(r_key_pos))) begin
                    p_key_pos = r_key_pos + 4'd1;
                    if (p_key_pos == KeyLen) begin
                        p_phase = VP_SKIP;
                    end
                end else begin
                    p_key_pos = (c == ChC) ? 4'd1 : 4'd0;
                end
            end
            VP_SKIP: begin
                priority if (is_space(c)) begin
                    p_phase = VP_SKIP;
                end else if ((c == ChPlus) || (c == ChMinus)) begin
                    p_neg   = (c == ChMinus);
                    p_phase = VP_DIGITS;
                end else if (c_digit) begin
                    p_parsed = {{(LengthBits-4){1'b0}}, digit};
                    p_phase  = VP_DIGITS;
                end else begin
                    p_phase = VP_DONE;
                end
            end
            VP_DIGITS: begin
                if (c_digit) begin
                    if (!r_sat) begin
                        if (acc > {4'b0, i_limit}) begin
                            p_parsed = i_limit;
                            p_sat    = 1'b1;
                        end else begin
                            p_parsed = acc[LengthBits-1:0];
                        end
                    end
                end else begin
                    p_phase = VP_DONE;
                end
            end
            VP_DONE: begin
                p_phase = VP_DONE;
            end
            default: begin
                p_phase = VP_DONE;
            end
        endcase
    end

    // Blank line detection.
    always_comb begin
        f_hdr  = 1'b0;
        b_next = BL_NONE;
        priority if (c == ChCr) begin
            b_next = (r_blank == BL_CRLF) ? BL_CRLFCR : BL_CR;
        end else if (c == ChLf) begin
            priority if (r_blank == BL_CR) begin
                b_next = BL_CRLF;
            end else if (r_blank == BL_CRLFCR) begin
                f_hdr = 1'b1;
            end else begin
                b_next = BL_NONE;
            end
        end else begin
            b_next = BL_NONE;
        end
    end

    // Message framing, next state and result.
    always_comb begin
        n_blank     = r_blank;
        n_hdr_done  = r_hdr_done;
        n_key_pos   = r_key_pos;
        n_phase     = r_phase;
        n_neg       = r_neg;
        n_parsed    = r_parsed;
        n_sat       = r_sat;
        n_remaining = r_remaining;
        n_count     = (r_count == CountMax) ? r_count : r_count + 1'b1;
        f_end       = 1'b0;
        f_clear     = 1'b0;

        o_result.out_byte     = c;
        o_result.in_body      = 1'b0;
        o_result.hdr_complete = 1'b0;
        o_result.message_end  = 1'b0;

        if (i_beat.cmd == CMD_CLOSE) begin
            f_clear                 = 1'b1;
            o_result.out_byte       = 8'h00;
            o_result.body_length    = r_hdr_done ? r_parsed : '0;
            o_result.message_length = r_count;
            o_result.status         = (r_count != '0) ? ST_ABORTED : ST_OK;
        end else begin
            if (r_hdr_done) begin
                o_result.in_body = 1'b1;
                if (r_remaining != '0) begin
                    n_remaining = r_remaining - 1'b1;
                end
                f_end = (n_remaining == '0);
            end else begin
                n_blank   = b_next;
                n_key_pos = p_key_pos;
                n_phase   = p_phase;
                n_neg     = p_neg;
                n_parsed  = p_parsed;
                n_sat     = p_sat;
                if (f_hdr) begin
                    n_hdr_done = 1'b1;
                    n_phase    = VP_DONE;
                    if (p_neg) begin
                        n_parsed = '0;
                        n_sat    = 1'b0;
                    end else if (p_parsed > i_limit) begin
                        n_parsed = i_limit;
                        n_sat    = 1'b1;
                    end
                    n_remaining = n_parsed;
                    f_end       = (n_parsed == '0);
                end
            end
            f_clear                 = f_end;
            o_result.hdr_complete   = f_hdr && !r_hdr_done;
            o_result.message_end    = f_end;
            o_result.body_length    = n_hdr_done ? n_parsed : '0;
            o_result.message_length = n_count;
            o_result.status         = (n_hdr_done && n_sat) ? ST_SATURATED : ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blank     <= BL_NONE;
            r_hdr_done  <= 1'b0;
            r_key_pos   <= '0;
            r_phase     <= VP_KEY;
            r_neg       <= 1'b0;
            r_parsed    <= '0;
            r_sat       <= 1'b0;
            r_remaining <= '0;
            r_count     <= '0;
        end else if (i_step) begin
            if (f_clear) begin
                r_blank     <= BL_NONE;
                r_hdr_done  <= 1'b0;
                r_key_pos   <= '0;
                r_phase     <= VP_KEY;
                r_neg       <= 1'b0;
                r_parsed    <= '0;
                r_sat       <= 1'b0;
                r_remaining <= '0;
                r_count     <= '0;
            end else begin
                r_blank     <= n_blank;
                r_hdr_done  <= n_hdr_done;
                r_key_pos   <= n_key_pos;
                r_phase     <= n_phase;
                r_neg       <= n_neg;
                r_parsed    <= n_parsed;
                r_sat       <= n_sat;
                r_remaining <= n_remaining;
                r_count     <= n_count;
            end
        end
    end

endmodule
`default_nettype wire

// ===== sv/http_request_framer.sv =====
// Top level of the HTTP request framer: input stage, framing engine, result register.
// Path: an accepted beat is held in the input register, then framed by the engine into the result register.
// Throughput: one beat per cycle while the output is not stalled, set by the single engine state update per beat.
// While a finished result waits, the input register takes one more beat, then stalls.
// Reset clears all message state and sets the length limit to its maximum.
`default_nettype none
module http_request_framer
    import hrf_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_in_beat              i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_out_beat                  o_out_data,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [LengthBits-1:0] i_cfg_data
);

    logic                  stage_valid;
    t_in_beat              stage_data;
    logic                  advance;
    t_out_beat             result;
    logic [LengthBits-1:0] r_limit;
    logic                  r_out_valid;
    t_out_beat             r_out_data;

    assign advance     = stage_valid && (!r_out_valid || i_out_ready);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    hrf_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_data  (i_in_data),
        .o_valid (stage_valid),
        .i_take  (advance),
        .o_data  (stage_data)
    );

    hrf_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_beat   (stage_data),
        .i_limit  (r_limit),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LengthMax;
        end else if (i_cfg_valid) begin
            r_limit <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || i_out_ready) begin
            r_out_valid <= stage_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data <= result;
        end
    end

endmodule
`default_nettype wire

// ===== tb/http_request_framer_checker.sv =====
// Checker for the HTTP request framer: predicts every result beat and compares it.
module http_request_framer_checker
    import hrf_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    input  wire logic                  i_in_ready,
    input  wire t_in_beat              i_in_data,
    input  wire logic                  i_out_valid,
    input  wire logic                  i_out_ready,
    input  wire t_out_beat             i_out_data,
    input  wire logic                  i_cfg_valid,
    input  wire logic                  i_cfg_ready,
    input  wire logic [LengthBits-1:0] i_cfg_data,
    output int                         o_fail_count,
    output int                         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [8*15-1:0] KeyText = "Content-Length:";
    localparam logic [7:0] CharCr = 8'h0D;
    localparam logic [7:0] CharLf = 8'h0A;

    logic [LengthBits-1:0] len_limit = '1;
    t_blank                crlf_seen = BL_NONE;
    logic                  in_payload = 1'b0;
    logic [3:0]            key_pos = '0;
    t_value_phase          num_phase = VP_KEY;
    logic                  num_neg = 1'b0;
    logic [LengthBits-1:0] num_val = '0;
    logic                  num_clamped = 1'b0;
    logic [LengthBits-1:0] body_left = '0;
    logic [CountBits-1:0]  msg_count = '0;

    t_out_beat framed_due[$];
    t_out_beat oldest;
    int        mismatches = 0;

    function automatic void clear_message();
        crlf_seen   = BL_NONE;
        in_payload  = 1'b0;
        key_pos     = '0;
        num_phase   = VP_KEY;
        num_neg     = 1'b0;
        num_val     = '0;
        num_clamped = 1'b0;
        body_left   = '0;
        msg_count   = '0;
    endfunction

    function automatic t_out_beat frame_byte(input t_in_beat beat);
        t_out_beat        res;
        logic [7:0]       c;
        longint unsigned  acc;
        logic             hdr_end;
        logic             last;
        res     = '0;
        c       = beat.data_byte;
        hdr_end = 1'b0;
        last    = 1'b0;
        if (beat.cmd == CMD_CLOSE) begin
            res.body_length    = in_payload ? num_val : '0;
            res.message_length = msg_count;
            res.status         = (msg_count != '0) ? ST_ABORTED : ST_OK;
            clear_message();
            return res;
        end
        if (msg_count != '1) begin
            msg_count = msg_count + 1'b1;
        end
        if (in_payload) begin
            res.in_body = 1'b1;
            if (body_left != '0) begin
                body_left = body_left - 1'b1;
            end
            if (body_left == '0) begin
                last = 1'b1;
            end
        end else begin
            case (num_phase)
                VP_KEY: begin
                    if (key_pos < 4'd15 && c == KeyText[8*(14-int'(key_pos)) +: 8]) begin
                        key_pos = key_pos + 1'b1;
                        if (key_pos == 4'd15) begin
                            num_phase = VP_SKIP;
                        end
                    end else begin
                        key_pos = (c == "C") ? 4'd1 : 4'd0;
                    end
                end
                VP_SKIP: begin
                    if (c inside {8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D}) begin
                        num_phase = VP_SKIP;
                    end else if (c == "+" || c == "-") begin
                        num_neg   = (c == "-");
                        num_phase = VP_DIGITS;
                    end else if (c >= "0" && c <= "9") begin
                        num_val   = LengthBits'(c - 8'h30);
                        num_phase = VP_DIGITS;
                    end else begin
                        num_phase = VP_DONE;
                    end
                end
                VP_DIGITS: begin
                    if (c >= "0" && c <= "9") begin
                        if (!num_clamped) begin
                            acc = longint'(num_val) * 10 + longint'(c - 8'h30);
                            if (acc > longint'(len_limit)) begin
                                acc         = longint'(len_limit);
                                num_clamped = 1'b1;
                            end
                            num_val = acc[LengthBits-1:0];
                        end
                    end else begin
                        num_phase = VP_DONE;
                    end
                end
                default: begin
                end
            endcase
            if (c == CharCr) begin
                crlf_seen = (crlf_seen == BL_CRLF) ? BL_CRLFCR : BL_CR;
            end else if (c == CharLf) begin
                if (crlf_seen == BL_CR) begin
                    crlf_seen = BL_CRLF;
                end else if (crlf_seen == BL_CRLFCR) begin
                    crlf_seen = BL_NONE;
                    hdr_end   = 1'b1;
                end else begin
                    crlf_seen = BL_NONE;
                end
            end else begin
                crlf_seen = BL_NONE;
            end
            if (hdr_end) begin
                in_payload = 1'b1;
                num_phase  = VP_DONE;
                if (num_neg) begin
                    num_val     = '0;
                    num_clamped = 1'b0;
                end else if (num_val > len_limit) begin
                    num_val     = len_limit;
                    num_clamped = 1'b1;
                end
                body_left = num_val;
                if (body_left == '0) begin
                    last = 1'b1;
                end
            end
        end
        res.out_byte       = c;
        res.hdr_complete   = hdr_end;
        res.message_end    = last;
        res.body_length    = in_payload ? num_val : '0;
        res.message_length = msg_count;
        res.status         = (in_payload && num_clamped) ? ST_SATURATED : ST_OK;
        if (last) begin
            clear_message();
        end
        return res;
    endfunction

    function automatic void compare_field(input string name, input longint unsigned want,
                                          input longint unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_message();
            len_limit = '1;
            framed_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                len_limit = i_cfg_data;
            end
            if (i_in_valid && i_in_ready) begin
                framed_due.push_back(frame_byte(i_in_data));
            end
            if (i_out_valid && i_out_ready) begin
                if (framed_due.size() == 0) begin
                    $display("%0t: result beat with none expected, expected none, actual %h",
                             $time, i_out_data);
                    mismatches++;
                end else begin
                    oldest = framed_due.pop_front();
                    compare_field("out_byte", oldest.out_byte, i_out_data.out_byte);
                    compare_field("in_body", oldest.in_body, i_out_data.in_body);
                    compare_field("hdr_complete", oldest.hdr_complete,
                                  i_out_data.hdr_complete);
                    compare_field("message_end", oldest.message_end, i_out_data.message_end);
                    compare_field("body_length", oldest.body_length, i_out_data.body_length);
                    compare_field("message_length", oldest.message_length,
                                  i_out_data.message_length);
                    compare_field("status", oldest.status, i_out_data.status);
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= framed_due.size();
    end

endmodule

// ===== tb/http_request_framer_test.sv =====
// Top of the HTTP request framer testbench: clock, reset, request traffic and verdict.
module http_request_framer_test
    import hrf_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int    QuietLimit = 2000;
    localparam string Crlf       = "\015\012";
    localparam logic [7:0] Blanks [4] = '{8'h20, 8'h09, 8'h0B, 8'h0C};

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    t_in_beat              in_data = '0;
    logic                  out_ready = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [LengthBits-1:0] cfg_data = '0;
    logic                  in_ready;
    logic                  out_valid;
    t_out_beat             out_data;
    logic                  cfg_ready;
    int                    fail_count;
    int                    pending;

    t_in_beat request_bytes[$];
    int       beats_sent = 0;
    int       burst_left = 0;
    int       quiet_cycles = 0;

    http_request_framer uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    http_request_framer_checker frame_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic void add_byte(input logic [7:0] b);
        request_bytes.push_back('{cmd: CMD_BYTE, data_byte: b});
    endfunction

    function automatic void add_close();
        request_bytes.push_back('{cmd: CMD_CLOSE, data_byte: 8'($urandom)});
    endfunction

    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            add_byte(s[i]);
        end
    endfunction

    function automatic string header_word();
        string s;
        s = "";
        repeat ($urandom_range(1, 6)) begin
            s = {s, string'(8'("a" + $urandom_range(0, 25)))};
        end
        return s;
    endfunction

    function automatic void build_request(input logic [LengthBits-1:0] lim);
        int              kind;
        int              cut;
        longint unsigned value;
        longint unsigned body;
        kind  = $urandom_range(0, 9);
        value = 0;
        add_text({"GET /", header_word(), " HTTP/1.1", Crlf});
        if ($urandom_range(0, 1)) begin
            add_text({"Host: ", header_word(), Crlf});
        end
        case (kind)
            1: begin
                value = $urandom_range(0, 40);
                add_text({"Content-Length: ", $sformatf("%0d", value), Crlf});
            end
            2: begin
                value = $urandom_range(0, 40);
                add_text("Content-Length:");
                repeat ($urandom_range(0, 3)) begin
                    add_byte(Blanks[$urandom_range(0, 3)]);
                end
                if ($urandom_range(0, 3) == 0) begin
                    add_text({Crlf, " "});
                end
                if ($urandom_range(0, 1)) begin
                    add_byte("+");
                end
                if ($urandom_range(0, 2) == 0) begin
                    add_text("00");
                end
                add_text({$sformatf("%0d", value), Crlf});
            end
            3: begin
                add_text({"Content-Length: -", $sformatf("%0d", $urandom_range(0, 99999)), Crlf});
            end
            4: begin
                add_text({"Content-Length: ", $urandom_range(0, 1) ? "+" : "-", Crlf});
            end
            5: begin
                add_text({"Content-Length: x", $sformatf("%0d", $urandom_range(1, 9)), Crlf});
            end
            6: begin
                value = longint'($urandom_range(1000, 999999)) * 1000000 +
                        $urandom_range(0, 999999);
                add_text({"Content-Length: ", $sformatf("%0d", value), Crlf});
            end
            7: begin
                value = $urandom_range(0, 40);
                add_text({"X-Content-Lengt", $urandom_range(0, 1) ? "C" : "",
                          "Content-Length:", $sformatf("%0d", value), Crlf});
            end
            8: begin
                add_text({"content-length: ", $sformatf("%0d", $urandom_range(1, 9)), Crlf});
            end
            9: begin
                value = $urandom_range(0, 40);
                add_text({"Content-Length: ", $sformatf("%0d", value), Crlf});
                add_text({"Content-Length: ", $sformatf("%0d", $urandom_range(0, 40)), Crlf});
            end
            default: begin
            end
        endcase
        if ($urandom_range(0, 2) == 0) begin
            add_text({"Accept: ", header_word(), Crlf});
        end
        add_text(Crlf);
        body = (value > longint'(lim)) ? longint'(lim) : value;
        if (body > 128) begin
            repeat ($urandom_range(0, 16)) begin
                add_byte(8'($urandom));
            end
            add_close();
        end else begin
            repeat (body) begin
                add_byte(8'($urandom));
            end
        end
        if ($urandom_range(0, 11) == 0) begin
            cut = $urandom_range(0, request_bytes.size() - 1);
            while (request_bytes.size() > cut) begin
                void'(request_bytes.pop_back());
            end
            add_close();
        end
    endfunction

    function automatic void build_noise();
        repeat ($urandom_range(1, 12)) begin
            case ($urandom_range(0, 3))
                0:       add_byte(8'h0D);
                1:       add_byte(8'h0A);
                2:       add_byte("C");
                default: add_byte(8'($urandom));
            endcase
        end
        if ($urandom_range(0, 1)) begin
            add_close();
        end
    endfunction

    task automatic send_beat(input t_in_beat beat);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data  <= beat;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        beats_sent++;
    endtask

    task automatic feed_queued();
        while (request_bytes.size() != 0) begin
            send_beat(request_bytes.pop_front());
        end
    endtask

    task automatic settle_framer();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic write_length_limit(input logic [LengthBits-1:0] lim);
        settle_framer();
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= lim;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial begin : receiver
        int  stretch;
        int  mode;
        int  hold_len;
        int  elapsed;
        bit  long_hold_done;
        elapsed        = 0;
        long_hold_done = 1'b0;
        forever begin
            hold_len = 0;
            if (!long_hold_done && elapsed > 1200) begin
                long_hold_done = 1'b1;
                hold_len       = 300;
            end else if ($urandom_range(0, 39) == 0) begin
                hold_len = $urandom_range(50, 250);
            end
            repeat (hold_len) begin
                @(posedge clk);
                out_ready <= 1'b0;
            end
            mode    = $urandom_range(0, 3);
            stretch = $urandom_range(10, 150);
            for (int k = 0; k < stretch; k++) begin
                @(posedge clk);
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom_range(0, 1));
                    2:       out_ready <= (k % 3 != 0);
                    default: out_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
            elapsed += stretch + hold_len;
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QuietLimit) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        logic [LengthBits-1:0] limits [7];
        int                    target;
        int                    pick;
        limits = '{24'hFFFFFF, 24'd0, 24'd1, 24'd9, 24'd100, 24'd0, 24'hFFFFFF};
        limits[5] = LengthBits'($urandom_range(10, 5000));
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_close();
        add_byte(8'h00);
        add_byte(8'hFF);
        add_close();
        add_text({Crlf, Crlf});
        add_text("\012\015\012\015\015\012\015\012");
        feed_queued();

        for (int p = 0; p < 7; p++) begin
            write_length_limit(limits[p]);
            target = beats_sent + 215;
            while (beats_sent < target) begin
                pick = $urandom_range(0, 19);
                if (pick < 16) begin
                    build_request(limits[p]);
                end else if (pick < 18) begin
                    build_noise();
                end else begin
                    add_close();
                end
                feed_queued();
            end
        end

        settle_framer();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
